>>> rtl/tsni_pkg.sv
// Package for the ClientHello server-name extractor.
// Holds the item structs, parse phase enum and status codes; no dependencies.
`timescale 1ns / 1ps

package tsni_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_byte_valid;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] name_length;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_HS_TYPE,
    PH_SKIP_FIXED,
    PH_SID_LEN,
    PH_SKIP_SID,
    PH_CIPHER_HI,
    PH_CIPHER_LO,
    PH_SKIP_CIPHER,
    PH_COMP_LEN,
    PH_SKIP_COMP,
    PH_EXT_TOTAL,
    PH_EXT_HDR,
    PH_SKIP_EXT,
    PH_SNI_LIST,
    PH_NAME_HDR,
    PH_NAME
  } phase_t;

  localparam logic [2:0] ST_FOUND         = 3'd0;
  localparam logic [2:0] ST_NOT_HANDSHAKE = 3'd1;
  localparam logic [2:0] ST_NOT_CHELLO    = 3'd2;
  localparam logic [2:0] ST_NO_SNI        = 3'd3;
  localparam logic [2:0] ST_BAD_NAME      = 3'd4;
  localparam logic [2:0] ST_TRUNCATED     = 3'd5;

  localparam logic [7:0]  CT_HANDSHAKE = 8'h16;
  localparam logic [7:0]  HS_CHELLO    = 8'h01;
  localparam logic [15:0] EXT_SNI      = 16'h0000;
  localparam logic [15:0] FIXED_SKIP   = 16'd37;
  localparam logic [16:0] POS_MAX      = 17'h1FFFF;

endpackage

>>> rtl/tls_client_hello_sni_extractor.sv
// TLS ClientHello server-name extractor, top level.
// Byte parser state and a two-entry result queue; uses tsni_pkg.
`timescale 1ns / 1ps

// Takes one record byte per cycle and streams out the server-name bytes of a
// ClientHello, then a single done item with a status and the name length.
// Each byte is handled in the cycle it is accepted: a small phase machine
// with 16-bit counters updates its state and any result goes straight into
// a two-entry queue, so one byte per clock is sustained while out_stall is low.
// in_stall rises only while both queue entries hold results that the
// consumer has not taken. Bytes after done are dropped without a result
// until the byte marked last, which returns the parser to its reset state.
// Streamed name bytes must be discarded unless the done status is found.
module tls_client_hello_sni_extractor #(
  parameter int MAX_NAME_LEN = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsni_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tsni_pkg::out_item_t out_item
);
  import tsni_pkg::*;

  // parser state
  logic [16:0] position, position_next;
  logic [16:0] record_end, record_end_next;
  phase_t      phase, phase_next;
  logic [15:0] skip_rem, skip_rem_next;
  logic [15:0] ext_rem, ext_rem_next;
  logic [15:0] ext_kind, ext_kind_next;
  logic [15:0] field_len, field_len_next;
  logic [7:0]  host_kind, host_kind_next;
  logic        finished, finished_next;

  // result queue
  out_item_t   slot0, slot1;
  logic [1:0]  count;

  logic        accept;
  logic        pop;
  logic        push;
  out_item_t   res;

  logic [7:0]  b;
  logic        lst;
  logic [15:0] fl_low;
  logic [15:0] skip_dec;
  logic [17:0] pos_inc;
  logic        ext_room;
  logic        name_fits;
  logic        do_ext_start;
  logic        clear_all;
  logic        r_bv;
  logic [7:0]  r_b;
  logic        r_done;
  logic [2:0]  r_st;
  logic [7:0]  r_len;

  assign accept = in_valid && !in_stall;
  assign b      = in_item.data_byte;
  assign lst    = in_item.last;
  assign fl_low = {field_len[15:8], b};
  assign skip_dec = skip_rem - 16'd1;
  assign pos_inc  = {1'b0, position} + 18'd1;
  assign ext_room = ({1'b0, position} + 18'd5) <= {1'b0, record_end};
  assign name_fits = (pos_inc + {2'b00, fl_low}) <= {1'b0, record_end};

  always_comb begin
    position_next   = position;
    record_end_next = record_end;
    phase_next      = phase;
    skip_rem_next   = skip_rem;
    ext_rem_next    = ext_rem;
    ext_kind_next   = ext_kind;
    field_len_next  = field_len;
    host_kind_next  = host_kind;
    finished_next   = finished;
    r_bv   = 1'b0;
    r_b    = 8'd0;
    r_done = 1'b0;
    r_st   = ST_FOUND;
    r_len  = 8'd0;
    do_ext_start = 1'b0;
    clear_all    = 1'b0;

    if (accept) begin
      if (finished) begin
        clear_all = lst;
      end else begin
        if (phase != PH_HDR && position >= record_end) begin
          r_done = 1'b1;
          r_st   = ST_NO_SNI;
        end else begin
          case (phase)
            PH_HDR: begin
              if (position == 17'd0 && b != CT_HANDSHAKE) begin
                r_done = 1'b1;
                r_st   = ST_NOT_HANDSHAKE;
              end else if (position == 17'd3) begin
                field_len_next = {b, 8'd0};
              end else if (position == 17'd4) begin
                record_end_next = 17'd5 + {1'b0, fl_low};
                phase_next      = PH_HS_TYPE;
              end
            end
            PH_HS_TYPE: begin
              if (b != HS_CHELLO) begin
                r_done = 1'b1;
                r_st   = ST_NOT_CHELLO;
              end else begin
                skip_rem_next = FIXED_SKIP;
                phase_next    = PH_SKIP_FIXED;
              end
            end
            PH_SKIP_FIXED: begin
              skip_rem_next = skip_dec;
              if (skip_dec == 16'd0) phase_next = PH_SID_LEN;
            end
            PH_SID_LEN: begin
              skip_rem_next = {8'd0, b};
              phase_next    = (b != 8'd0) ? PH_SKIP_SID : PH_CIPHER_HI;
            end
            PH_SKIP_SID: begin
              skip_rem_next = skip_dec;
              if (skip_dec == 16'd0) phase_next = PH_CIPHER_HI;
            end
            PH_CIPHER_HI: begin
              field_len_next = {b, 8'd0};
              phase_next     = PH_CIPHER_LO;
            end
            PH_CIPHER_LO: begin
              field_len_next = fl_low;
              skip_rem_next  = fl_low;
              phase_next     = (fl_low != 16'd0) ? PH_SKIP_CIPHER : PH_COMP_LEN;
            end
            PH_SKIP_CIPHER: begin
              skip_rem_next = skip_dec;
              if (skip_dec == 16'd0) phase_next = PH_COMP_LEN;
            end
            PH_COMP_LEN: begin
              skip_rem_next = {8'd0, b};
              phase_next    = (b != 8'd0) ? PH_SKIP_COMP : PH_EXT_TOTAL;
            end
            PH_SKIP_COMP: begin
              skip_rem_next = skip_dec;
              if (skip_dec == 16'd0) phase_next = PH_EXT_TOTAL;
            end
            PH_EXT_TOTAL: begin
              if (skip_rem == 16'd0) begin
                ext_rem_next  = {b, 8'd0};
                skip_rem_next = 16'd1;
              end else begin
                ext_rem_next = {ext_rem[15:8], b};
                do_ext_start = 1'b1;
              end
            end
            PH_EXT_HDR: begin
              // skip_rem counts the four header bytes
              if (skip_rem == 16'd0) begin
                ext_kind_next = {b, 8'd0};
                skip_rem_next = 16'd1;
              end else if (skip_rem == 16'd1) begin
                ext_kind_next = {ext_kind[15:8], b};
                skip_rem_next = 16'd2;
              end else if (skip_rem == 16'd2) begin
                field_len_next = {b, 8'd0};
                skip_rem_next  = 16'd3;
              end else begin
                field_len_next = fl_low;
                if (ext_kind == EXT_SNI) begin
                  phase_next    = PH_SNI_LIST;
                  skip_rem_next = 16'd0;
                end else begin
                  ext_rem_next  = ext_rem - 16'd4 - fl_low;
                  skip_rem_next = fl_low;
                  if (fl_low == 16'd0) do_ext_start = 1'b1;
                  else phase_next = PH_SKIP_EXT;
                end
              end
            end
            PH_SKIP_EXT: begin
              skip_rem_next = skip_dec;
              if (skip_dec == 16'd0) do_ext_start = 1'b1;
            end
            PH_SNI_LIST: begin
              if (skip_rem == 16'd0) begin
                skip_rem_next = 16'd1;
              end else begin
                phase_next    = PH_NAME_HDR;
                skip_rem_next = 16'd0;
              end
            end
            PH_NAME_HDR: begin
              if (skip_rem == 16'd0) begin
                host_kind_next = b;
                skip_rem_next  = 16'd1;
              end else if (skip_rem == 16'd1) begin
                field_len_next = {b, 8'd0};
                skip_rem_next  = 16'd2;
              end else begin
                field_len_next = fl_low;
                if (host_kind == 8'd0 && name_fits &&
                    fl_low < 16'(MAX_NAME_LEN)) begin
                  if (fl_low == 16'd0) begin
                    r_done = 1'b1;
                    r_st   = ST_FOUND;
                  end else begin
                    skip_rem_next = fl_low;
                    phase_next    = PH_NAME;
                  end
                end else begin
                  r_done = 1'b1;
                  r_st   = ST_BAD_NAME;
                end
              end
            end
            PH_NAME: begin
              r_bv = 1'b1;
              r_b  = b;
              skip_rem_next = skip_dec;
              if (skip_dec == 16'd0) begin
                r_done = 1'b1;
                r_st   = ST_FOUND;
                r_len  = field_len[7:0];
              end
            end
            default: begin
              r_done = 1'b1;
              r_st   = ST_NO_SNI;
            end
          endcase

          // start of the next extension header
          if (do_ext_start) begin
            if (ext_rem_next == 16'd0 || !ext_room) begin
              r_done = 1'b1;
              r_st   = ST_NO_SNI;
            end else begin
              phase_next    = PH_EXT_HDR;
              skip_rem_next = 16'd0;
            end
          end
        end

        if (lst && !r_done) begin
          r_done = 1'b1;
          r_st   = ST_TRUNCATED;
          r_len  = 8'd0;
        end

        if (lst) begin
          clear_all = 1'b1;
        end else begin
          if (r_done) finished_next = 1'b1;
          if (position != POS_MAX) position_next = pos_inc[16:0];
        end
      end
    end

    if (clear_all) begin
      position_next   = 17'd0;
      record_end_next = 17'd0;
      phase_next      = PH_HDR;
      skip_rem_next   = 16'd0;
      ext_rem_next    = 16'd0;
      ext_kind_next   = 16'd0;
      field_len_next  = 16'd0;
      host_kind_next  = 8'd0;
      finished_next   = 1'b0;
    end

    res.name_byte       = r_b;
    res.name_byte_valid = r_bv;
    res.done_res        = r_done;
    res.status          = r_done ? r_st : ST_FOUND;
    res.name_length     = (r_done && r_st == ST_FOUND) ? r_len : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= 17'd0;
      record_end <= 17'd0;
      phase      <= PH_HDR;
      skip_rem   <= 16'd0;
      ext_rem    <= 16'd0;
      ext_kind   <= 16'd0;
      field_len  <= 16'd0;
      host_kind  <= 8'd0;
      finished   <= 1'b0;
    end else begin
      position   <= position_next;
      record_end <= record_end_next;
      phase      <= phase_next;
      skip_rem   <= skip_rem_next;
      ext_rem    <= ext_rem_next;
      ext_kind   <= ext_kind_next;
      field_len  <= field_len_next;
      host_kind  <= host_kind_next;
      finished   <= finished_next;
    end
  end

  // two-entry result queue, slot0 is the head
  assign push      = accept && (r_bv || r_done);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (count == 2'd2);
  assign out_item  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) slot0 <= res;
      else slot1 <= res;
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        slot0 <= res;
      end else begin
        slot0 <= slot1;
        slot1 <= res;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.done_res || out_item.status == ST_FOUND))
    else $error("status set on an item without done");

  a_item_carries_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.name_byte_valid || out_item.done_res))
    else $error("empty result item queued");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_item.last) |=>
      (phase == PH_HDR && !finished && position == 17'd0))
    else $error("parser not back at record start after last byte");
`endif

endmodule
